// File: hdl/assert_macros.svh
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsi assertion failed");

// Next-cycle implication
`define TSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsi assertion failed");

`endif

// File: hdl/tsi_pkg.sv
package tsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SETUP  = 2'd1;
  localparam logic [1:0] OP_TOP    = 2'd2;
  localparam logic [1:0] OP_BOTTOM = 2'd3;

  localparam logic [1:0] ATTR_X = 2'd0;
  localparam logic [1:0] ATTR_U = 2'd1;
  localparam logic [1:0] ATTR_V = 2'd2;
  localparam logic [1:0] ATTR_W = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         vertex_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] tex_w;
    logic               is_textured;
    logic signed [31:0] offset_from_top;
    logic signed [31:0] offset_from_middle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] span_left_x;
    logic signed [31:0] span_right_x;
    logic signed [31:0] left_u;
    logic signed [31:0] left_v;
    logic signed [31:0] left_w;
    logic signed [31:0] right_u;
    logic signed [31:0] right_v;
    logic signed [31:0] right_w;
  } out_t;

  // multiply-add request and result
  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic signed [31:0] base;
    logic signed [31:0] off;
    logic signed [31:0] step;
  } mac_req_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic signed [31:0] value;
  } mac_res_t;

endpackage

// File: hdl/tsi_div.sv
`include "assert_macros.svh"

module tsi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] diff,
  input  logic signed [32:0] dy,
  output logic               done,
  output logic signed [31:0] quot
);
  import tsi_pkg::*;

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [32:0]   den_r;
  logic [32:0]   rem_r;
  logic          neg_r;
  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic signed [31:0] quot_r;

  logic [32:0] mag_n, mag_d;
  logic [33:0] trial;
  logic        ge;
  logic [NW-1:0] quo_nxt;
  logic [32:0]   rem_nxt;
  logic signed [31:0] sat;

  always_comb begin
    mag_n   = diff[32] ? -diff : diff;
    mag_d   = dy[32] ? -dy : dy;
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
    quo_nxt = {quo_r[NW-2:0], ge};
    if (neg_r) begin
      if ((|quo_nxt[NW-1:32]) || (quo_nxt[31] && (|quo_nxt[30:0]))) begin
        sat = 32'sh8000_0000;
      end else begin
        sat = -$signed(quo_nxt[31:0]);
      end
    end else begin
      sat = (|quo_nxt[NW-1:31]) ? 32'sh7fff_ffff : $signed(quo_nxt[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= {mag_n, {FRAC_BITS{1'b0}}};
        den_r  <= mag_d;
        rem_r  <= '0;
        neg_r  <= diff[32] ^ dy[32];
        cnt_r  <= CW'(NW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= sat;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  `TSI_ASSERT_IMP(a_no_restart, start, !busy_r)
  `TSI_ASSERT_IMP(a_done_idle, done_r, !busy_r)
  `TSI_ASSERT_NXT(a_done_pulse, done_r, !done_r)

endmodule

// File: hdl/tsi_mac.sv
`include "assert_macros.svh"

module tsi_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  tsi_pkg::mac_req_t req,
  output tsi_pkg::mac_res_t res
);
  import tsi_pkg::*;

  localparam int SW = 65 - FRAC_BITS;

  logic signed [63:0] prod_r;
  logic signed [31:0] base_r;
  logic [2:0]         idx1_r;
  logic               v1_r;
  mac_res_t           res_r;
  logic [SW-1:0]      sum;

  always_comb begin
    sum = {{(SW-32){base_r[31]}}, base_r} + {prod_r[63], prod_r[63:FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      v1_r        <= req.valid;
      res_r.valid <= v1_r;
    end
    prod_r    <= req.off * req.step;
    base_r    <= req.base;
    idx1_r    <= req.idx;
    res_r.idx <= idx1_r;
    if ((&sum[SW-1:31]) || !(|sum[SW-1:31])) begin
      res_r.value <= $signed(sum[31:0]);
    end else begin
      res_r.value <= sum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign res = res_r;

  `TSI_ASSERT_NXT(a_latency, v1_r, res_r.valid)
  `TSI_ASSERT_NXT(a_stage_one, req.valid, v1_r)
  `TSI_ASSERT_NXT(a_no_spurious, !v1_r, !res_r.valid)

endmodule

// File: hdl/triangle_span_interpolator.sv
// Triangle span interpolator. A load transaction's zero result strobes on
// out_valid the cycle after start. In a span transaction the eight end
// values (x, u, v, w at both ends) go one per cycle through a single
// two-stage 32x32 multiply-add unit, then the ends are ordered by x. A setup
// transaction sorts the three vertices by y, then runs up to twelve
// divisions on one shared bit-serial divider. busy is high while a setup or
// span transaction is in work; each result appears for exactly one cycle
// with out_valid and cannot be held off, so the receiver must take it then.
`include "assert_macros.svh"

module triangle_span_interpolator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tsi_pkg::in_t  in_data,
  output logic          out_valid,
  output tsi_pkg::out_t out_data
);
  import tsi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SORT, ST_DIV_START, ST_DIV_WAIT, ST_SPAN, ST_OUT
  } state_t;

  state_t state_r;
  logic [3:0] cnt_r;
  logic [3:0] rcnt_r;
  logic signed [31:0] vx_r [3];
  logic signed [31:0] vy_r [3];
  logic signed [31:0] vu_r [3];
  logic signed [31:0] vv_r [3];
  logic signed [31:0] vw_r [3];
  logic signed [31:0] steps_r [12];
  logic signed [31:0] res_r [8];
  logic tex_r;
  logic bottom_r;
  logic signed [31:0] top_r, mid_r;
  logic out_valid_r;
  out_t out_data_r;

  logic in_acc;
  // sort
  logic [1:0] si, sj;
  logic       sswap;
  // setup
  logic [1:0] ea, eb, attr_s;
  logic signed [32:0] dyv, dif;
  logic skip_div, last_step;
  logic div_start, div_done;
  logic signed [31:0] div_q;
  // span
  logic [2:0] k;
  logic [1:0] attr_k;
  logic       side_a_bot;
  logic [1:0] vi;
  logic [3:0] sidx;
  mac_req_t   req;
  mac_res_t   mres;
  logic       swap_ends;

  function automatic logic signed [31:0] attr_of(
    input logic [1:0] at, input logic signed [31:0] x, input logic signed [31:0] u,
    input logic signed [31:0] v, input logic signed [31:0] w);
    logic signed [31:0] r;
    case (at)
      ATTR_X:  r = x;
      ATTR_U:  r = u;
      ATTR_V:  r = v;
      ATTR_W:  r = w;
      default: r = x;
    endcase
    return r;
  endfunction

  assign in_acc = start && !busy;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin si = 2'd0; sj = 2'd1; end
      2'd1:    begin si = 2'd0; sj = 2'd2; end
      default: begin si = 2'd1; sj = 2'd2; end
    endcase
    sswap = vy_r[sj] < vy_r[si];

    case (cnt_r[3:2])
      2'd0:    begin eb = 2'd0; ea = 2'd1; end
      2'd1:    begin eb = 2'd0; ea = 2'd2; end
      default: begin eb = 2'd1; ea = 2'd2; end
    endcase
    attr_s = cnt_r[1:0];
    dyv = 33'(vy_r[ea]) - 33'(vy_r[eb]);
    dif = 33'(attr_of(attr_s, vx_r[ea], vu_r[ea], vv_r[ea], vw_r[ea]))
        - 33'(attr_of(attr_s, vx_r[eb], vu_r[eb], vv_r[eb], vw_r[eb]));
    skip_div  = (dyv == '0) || (!tex_r && (attr_s == ATTR_U || attr_s == ATTR_V));
    last_step = cnt_r == 4'd11;
    div_start = (state_r == ST_DIV_START) && !skip_div;

    k          = cnt_r[2:0];
    attr_k     = k[1:0];
    side_a_bot = !k[2] && bottom_r;
    vi         = side_a_bot ? 2'd1 : 2'd0;
    sidx       = k[2] ? {2'b01, attr_k} : (bottom_r ? {2'b10, attr_k} : {2'b00, attr_k});
    req.valid  = (state_r == ST_SPAN) && !cnt_r[3];
    req.idx    = k;
    req.base   = attr_of(attr_k, vx_r[vi], vu_r[vi], vv_r[vi], vw_r[vi]);
    req.off    = side_a_bot ? mid_r : top_r;
    req.step   = steps_r[sidx];

    swap_ends = res_r[0] > res_r[4];
  end

  tsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .diff  (dif),
    .dy    (dyv),
    .done  (div_done),
    .quot  (div_q)
  );

  tsi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rcnt_r      <= '0;
      tex_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0; vy_r[i] <= '0; vu_r[i] <= '0; vv_r[i] <= '0; vw_r[i] <= '0;
      end
      for (int i = 0; i < 12; i++) begin
        steps_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r  <= '0;
            rcnt_r <= '0;
            case (in_data.opcode)
              OP_LOAD: begin
                if (in_data.vertex_index != 2'd3) begin
                  vx_r[in_data.vertex_index] <= in_data.coord_x;
                  vy_r[in_data.vertex_index] <= in_data.coord_y;
                  vu_r[in_data.vertex_index] <= in_data.tex_u;
                  vv_r[in_data.vertex_index] <= in_data.tex_v;
                  vw_r[in_data.vertex_index] <= in_data.tex_w;
                end
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end
              OP_SETUP: begin
                tex_r   <= in_data.is_textured;
                state_r <= ST_SORT;
              end
              default: begin
                bottom_r <= in_data.opcode == OP_BOTTOM;
                top_r    <= in_data.offset_from_top;
                mid_r    <= in_data.offset_from_middle;
                state_r  <= ST_SPAN;
              end
            endcase
          end
        end
        ST_SORT: begin
          if (sswap) begin
            vx_r[si] <= vx_r[sj]; vx_r[sj] <= vx_r[si];
            vy_r[si] <= vy_r[sj]; vy_r[sj] <= vy_r[si];
            vu_r[si] <= vu_r[sj]; vu_r[sj] <= vu_r[si];
            vv_r[si] <= vv_r[sj]; vv_r[sj] <= vv_r[si];
            vw_r[si] <= vw_r[sj]; vw_r[sj] <= vw_r[si];
          end
          if (cnt_r == 4'd2) begin
            cnt_r   <= '0;
            state_r <= ST_DIV_START;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV_START, ST_DIV_WAIT: begin
          if (state_r == ST_DIV_START && !skip_div) begin
            state_r <= ST_DIV_WAIT;
          end else if (state_r == ST_DIV_START || div_done) begin
            steps_r[cnt_r] <= (state_r == ST_DIV_START) ? 32'sd0 : div_q;
            if (last_step) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
              state_r     <= ST_IDLE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= ST_DIV_START;
            end
          end
        end
        ST_SPAN: begin
          if (!cnt_r[3]) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (mres.valid) begin
            // drop u and v when untextured
            res_r[mres.idx] <= (!tex_r && (mres.idx[1:0] == ATTR_U ||
                                mres.idx[1:0] == ATTR_V)) ? 32'sd0 : mres.value;
            rcnt_r <= rcnt_r + 1'b1;
            if (rcnt_r == 4'd7) begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          out_valid_r <= 1'b1;
          if (swap_ends) begin
            out_data_r <= '{res_r[4], res_r[0], res_r[5], res_r[6], res_r[7],
                            res_r[1], res_r[2], res_r[3]};
          end else begin
            out_data_r <= '{res_r[0], res_r[4], res_r[1], res_r[2], res_r[3],
                            res_r[5], res_r[6], res_r[7]};
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSI_ASSERT_NXT(a_work_busy, in_acc && in_data.opcode != OP_LOAD, busy)
  `TSI_ASSERT_IMP(a_strobe_idle, out_valid_r, state_r == ST_IDLE)
  `TSI_ASSERT_IMP(a_mac_in_span, mres.valid, state_r == ST_SPAN)

endmodule
